// File: src/multibyte_character_assembler_assert.svh
`ifndef MULTIBYTE_CHARACTER_ASSEMBLER_ASSERT_SVH
`define MULTIBYTE_CHARACTER_ASSEMBLER_ASSERT_SVH

// Checks a property on every clock edge outside of reset.
`define MCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that a condition implies another one on the following edge.
`define MCA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

// File: src/mca_pkg.sv
package mca_pkg;

    typedef logic [1:0] t_enc;
    typedef logic [2:0] t_cls;

    localparam t_enc ENC_SJIS  = 2'd0;
    localparam t_enc ENC_UTF8  = 2'd1;
    localparam t_enc ENC_UTF16 = 2'd2;
    localparam t_enc ENC_BYTE  = 2'd3;

    localparam t_cls CLS_NUL    = 3'd0;
    localparam t_cls CLS_SINGLE = 3'd1;
    localparam t_cls CLS_BAD    = 3'd2;
    localparam t_cls CLS_LEAD1  = 3'd3;
    localparam t_cls CLS_LEAD2  = 3'd4;
    localparam t_cls CLS_LEAD3  = 3'd5;

    localparam logic [7:0] BIT7_MASK   = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'he0;
    localparam logic [7:0] LEAD2_CODE  = 8'hc0;
    localparam logic [7:0] LEAD3_MASK  = 8'hf0;
    localparam logic [7:0] LEAD3_CODE  = 8'he0;
    localparam logic [7:0] LEAD4_MASK  = 8'hf8;
    localparam logic [7:0] LEAD4_CODE  = 8'hf0;
    localparam logic [7:0] REPLACE_CHR = 8'h3f;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        t_cls       cls;
    } t_item;

    typedef struct packed {
        logic [31:0] char_code;
        logic [2:0]  code_bytes;
        logic        malformed;
        logic        truncated;
        logic        end_of_text;
    } t_result;

endpackage

// File: src/multibyte_character_assembler.sv
// A byte that completes a character is registered into the classifier queue, then passes through
// the assembler into the result queue, which drives the result ports.
// Throughput: one byte per cycle while the result queue has room; two-entry queues on either
// side of the assembler let the input and result sides stall independently.
// Reset (synchronous, active low): encoding returns to UTF-8, the partial character is dropped and
// both queues are emptied.
module multibyte_character_assembler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  mca_pkg::t_enc        i_cfg_encoding,
    output logic                 empty,
    input  logic                 pop,
    output logic [31:0]          o_char_code,
    output logic [2:0]           o_code_bytes,
    output logic                 o_malformed,
    output logic                 o_truncated,
    output logic                 o_end_of_text
);
    import mca_pkg::*;

    logic    cfg_wr;
    t_enc    encoding;
    logic    item_valid;
    t_item   item;
    logic    item_take;
    t_result result;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    mca_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_cfg_wr       (cfg_wr),
        .i_cfg_encoding (i_cfg_encoding),
        .o_encoding     (encoding),
        .o_item_valid   (item_valid),
        .o_item         (item),
        .i_item_take    (item_take)
    );

    mca_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (cfg_wr),
        .i_encoding   (encoding),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .empty        (empty),
        .pop          (pop),
        .o_result     (result)
    );

    assign o_char_code   = result.char_code;
    assign o_code_bytes  = result.code_bytes;
    assign o_malformed   = result.malformed;
    assign o_truncated   = result.truncated;
    assign o_end_of_text = result.end_of_text;

endmodule

// File: src/mca_front.sv
module mca_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    i_data_byte,
    input  logic          i_cfg_wr,
    input  mca_pkg::t_enc i_cfg_encoding,
    output mca_pkg::t_enc o_encoding,
    output logic          o_item_valid,
    output mca_pkg::t_item o_item,
    input  logic          i_item_take
);
    import mca_pkg::*;

    t_enc           r_encoding;
    t_item          r_queue [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_cnt;
    logic [QCW-1:0] n_cnt;
    t_cls           cls;
    logic           do_push;
    logic           do_pop;

    always_comb begin
        if (i_data_byte == 8'd0) begin
            cls = CLS_NUL;
        end else begin
            unique case (r_encoding)
                ENC_SJIS: begin
                    cls = ((i_data_byte & BIT7_MASK) != 8'd0) ? CLS_LEAD1 : CLS_SINGLE;
                end
                ENC_UTF8: begin
                    if ((i_data_byte & BIT7_MASK) == 8'd0) begin
                        cls = CLS_SINGLE;
                    end else if ((i_data_byte & LEAD2_MASK) == LEAD2_CODE) begin
                        cls = CLS_LEAD1;
                    end else if ((i_data_byte & LEAD3_MASK) == LEAD3_CODE) begin
                        cls = CLS_LEAD2;
                    end else if ((i_data_byte & LEAD4_MASK) == LEAD4_CODE) begin
                        cls = CLS_LEAD3;
                    end else begin
                        cls = CLS_BAD;
                    end
                end
                ENC_UTF16: cls = CLS_LEAD1;
                default:   cls = CLS_SINGLE;
            endcase
        end
    end

    assign full         = (r_cnt == QCW'(QDEPTH));
    assign do_push      = push && !full;
    assign o_item_valid = (r_cnt != '0);
    assign do_pop       = i_item_take && o_item_valid;
    assign o_item       = r_queue[r_rptr];
    assign o_encoding   = r_encoding;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding <= ENC_UTF8;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_encoding <= i_cfg_encoding;
            end
            if (do_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_queue[r_wptr] <= '{data: i_data_byte, cls: cls};
        end
    end

endmodule

// File: src/mca_back.sv
`include "multibyte_character_assembler_assert.svh"

module mca_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr,
    input  mca_pkg::t_enc  i_encoding,
    input  logic           i_item_valid,
    input  mca_pkg::t_item i_item,
    output logic           o_item_take,
    output logic           empty,
    input  logic           pop,
    output mca_pkg::t_result o_result
);
    import mca_pkg::*;

    logic [23:0]    r_partial;
    logic [1:0]     r_left;
    logic [2:0]     r_taken;
    logic [23:0]    n_partial;
    logic [1:0]     n_left;
    logic [2:0]     n_taken;
    t_result        r_oq [QDEPTH];
    logic [QAW-1:0] r_owptr;
    logic [QAW-1:0] r_orptr;
    logic [QCW-1:0] r_ocnt;
    logic [QCW-1:0] n_ocnt;
    logic           take;
    logic           emit;
    t_result        res;
    logic           do_pop;
    logic [31:0]    shifted;

    assign o_item_take = i_item_valid && (r_ocnt != QCW'(QDEPTH));
    assign take        = o_item_take;
    assign shifted     = {r_partial, i_item.data};

    always_comb begin
        n_partial = r_partial;
        n_left    = r_left;
        n_taken   = r_taken;
        emit      = 1'b0;
        res       = '0;
        if (r_left != 2'd0) begin
            if (i_encoding == ENC_UTF16) begin
                emit           = 1'b1;
                res.char_code  = {16'd0, i_item.data, r_partial[7:0]};
                res.code_bytes = 3'd2;
                n_partial      = '0;
                n_left         = '0;
                n_taken        = '0;
            end else if (i_item.cls == CLS_NUL) begin
                emit            = 1'b1;
                res.char_code   = {8'd0, r_partial};
                res.code_bytes  = r_taken;
                res.truncated   = 1'b1;
                res.end_of_text = 1'b1;
                n_partial       = '0;
                n_left          = '0;
                n_taken         = '0;
            end else if (r_left == 2'd1) begin
                emit           = 1'b1;
                res.char_code  = shifted;
                res.code_bytes = r_taken + 3'd1;
                n_partial      = '0;
                n_left         = '0;
                n_taken        = '0;
            end else begin
                n_partial = shifted[23:0];
                n_left    = r_left - 2'd1;
                n_taken   = r_taken + 3'd1;
            end
        end else begin
            unique case (i_item.cls)
                CLS_NUL: begin
                    emit            = 1'b1;
                    res.end_of_text = 1'b1;
                end
                CLS_SINGLE: begin
                    emit           = 1'b1;
                    res.char_code  = {24'd0, i_item.data};
                    res.code_bytes = 3'd1;
                end
                CLS_BAD: begin
                    emit           = 1'b1;
                    res.char_code  = {24'd0, REPLACE_CHR};
                    res.code_bytes = 3'd1;
                    res.malformed  = 1'b1;
                end
                CLS_LEAD1, CLS_LEAD2, CLS_LEAD3: begin
                    n_partial = {16'd0, i_item.data};
                    n_taken   = 3'd1;
                    n_left    = (i_item.cls == CLS_LEAD1) ? 2'd1 :
                                (i_item.cls == CLS_LEAD2) ? 2'd2 : 2'd3;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign empty    = (r_ocnt == '0);
    assign do_pop   = pop && !empty;
    assign o_result = r_oq[r_orptr];

    always_comb begin
        n_ocnt = r_ocnt;
        if (take && emit && !do_pop) begin
            n_ocnt = r_ocnt + QCW'(1);
        end else if (do_pop && !(take && emit)) begin
            n_ocnt = r_ocnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_left    <= '0;
            r_taken   <= '0;
            r_owptr   <= '0;
            r_orptr   <= '0;
            r_ocnt    <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_partial <= '0;
                r_left    <= '0;
                r_taken   <= '0;
            end else if (take) begin
                r_partial <= n_partial;
                r_left    <= n_left;
                r_taken   <= n_taken;
            end
            if (take && emit) begin
                r_owptr <= r_owptr + QAW'(1);
            end
            if (do_pop) begin
                r_orptr <= r_orptr + QAW'(1);
            end
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_oq[r_owptr] <= res;
        end
    end

    `MCA_ASSERT(a_ocnt_bound, r_ocnt <= QCW'(QDEPTH), "result queue overflow")
    `MCA_ASSERT(a_seq_len, (r_left == 2'd0) || ((r_taken != 3'd0) && ({1'b0, r_taken} + {2'd0, r_left} <= 4'd4)), "partial character length out of range")
    `MCA_ASSERT_NEXT(a_idle_after_emit, take && emit && !i_cfg_wr, r_left == 2'd0, "state not idle after a word was produced")

endmodule

// File: dv/tb_multibyte_character_assembler.sv
`timescale 1ns / 100ps

module tb_multibyte_character_assembler;
    import mca_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES   = 105;
    localparam int MAX_GAP       = 17;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_enc        i_cfg_encoding = ENC_UTF8;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_char_code;
    logic [2:0]  o_code_bytes;
    logic        o_malformed;
    logic        o_truncated;
    logic        o_end_of_text;

    t_enc phase_plan [8] = '{ENC_SJIS, ENC_UTF8, ENC_UTF16, ENC_BYTE,
                             ENC_UTF16, ENC_SJIS, ENC_BYTE, ENC_UTF8};

    logic [7:0] text_bytes [$];
    t_result    expected_chars [$];
    int         text_len = 0;
    int         text_sent = 0;
    int         tx_max_gap = MAX_GAP;
    int         rx_max_gap = MAX_GAP;
    int         tx_wait = 0;
    int         rx_wait = 0;
    int         hold_req = 0;
    int         hold_seen = 0;
    int         rx_hold = 0;
    int         err_count = 0;
    int         stall_cycles = 0;

    t_enc        enc_setting = ENC_UTF8;
    logic [23:0] pend_code = '0;
    logic [1:0]  pend_need = '0;
    logic [2:0]  pend_count = '0;

    multibyte_character_assembler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_encoding (i_cfg_encoding),
        .empty          (empty),
        .pop            (pop),
        .o_char_code    (o_char_code),
        .o_code_bytes   (o_code_bytes),
        .o_malformed    (o_malformed),
        .o_truncated    (o_truncated),
        .o_end_of_text  (o_end_of_text)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void drop_partial();
        pend_code  = '0;
        pend_need  = '0;
        pend_count = '0;
    endfunction

    function automatic void open_char(input logic [7:0] b, input logic [1:0] more);
        pend_code  = {16'd0, b};
        pend_count = 3'd1;
        pend_need  = more;
    endfunction

    function automatic bit predict_char(input logic [7:0] b, output t_result r);
        logic [31:0] code;
        r = '0;
        code = {pend_code, b};
        if (pend_need != 2'd0) begin
            if (enc_setting == ENC_UTF16) begin
                r.char_code  = {16'd0, b, pend_code[7:0]};
                r.code_bytes = 3'd2;
                drop_partial();
                return 1'b1;
            end
            if (b == 8'h00) begin
                r.char_code   = {8'd0, pend_code};
                r.code_bytes  = pend_count;
                r.truncated   = 1'b1;
                r.end_of_text = 1'b1;
                drop_partial();
                return 1'b1;
            end
            pend_need  = pend_need - 2'd1;
            pend_count = pend_count + 3'd1;
            if (pend_need == 2'd0) begin
                r.char_code  = code;
                r.code_bytes = pend_count;
                drop_partial();
                return 1'b1;
            end
            pend_code = code[23:0];
            return 1'b0;
        end
        if (b == 8'h00) begin
            r.end_of_text = 1'b1;
            return 1'b1;
        end
        r.char_code  = {24'd0, b};
        r.code_bytes = 3'd1;
        case (enc_setting)
            ENC_SJIS: begin
                if ((b & BIT7_MASK) != 8'h00) begin
                    open_char(b, 2'd1);
                    return 1'b0;
                end
            end
            ENC_UTF8: begin
                if ((b & BIT7_MASK) == 8'h00) begin
                    return 1'b1;
                end
                if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                    open_char(b, 2'd1);
                    return 1'b0;
                end
                if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                    open_char(b, 2'd2);
                    return 1'b0;
                end
                if ((b & LEAD4_MASK) == LEAD4_CODE) begin
                    open_char(b, 2'd3);
                    return 1'b0;
                end
                r.char_code = {24'd0, REPLACE_CHR};
                r.malformed = 1'b1;
            end
            ENC_UTF16: begin
                open_char(b, 2'd1);
                return 1'b0;
            end
            default: begin
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= 10) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
            end
        end
    endfunction

    task automatic queue_packed(input logic [255:0] list, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            text_bytes.push_back(list[8*i +: 8]);
            text_len++;
        end
    endtask

    // Mostly well-formed characters with random content, plus ends of text,
    // sequences cut short by a NUL, and random noise bytes.
    task automatic add_text(input t_enc enc, input int nbytes);
        logic [7:0] seq [$];
        int added;
        int kind;
        int len;
        int trail;
        added = 0;
        while (added < nbytes) begin
            seq.delete();
            kind = $urandom_range(0, 19);
            len = (enc == ENC_SJIS) ? 2 : $urandom_range(2, 4);
            if (kind == 0) begin
                seq.push_back(8'h00);
            end else if (kind == 1) begin
                seq.push_back(8'($urandom_range(0, 255)));
            end else if (enc == ENC_BYTE) begin
                seq.push_back(8'($urandom_range(1, 255)));
            end else if (enc == ENC_UTF16) begin
                seq.push_back(8'($urandom_range(1, 255)));
                seq.push_back((kind == 2) ? 8'h00 : 8'($urandom_range(0, 255)));
            end else if (enc == ENC_UTF8 && kind == 3) begin
                seq.push_back(BIT7_MASK | 8'($urandom_range(0, 63)));
            end else if (enc == ENC_UTF8 && kind == 4) begin
                seq.push_back(LEAD4_MASK | 8'($urandom_range(0, 7)));
            end else if (kind > 2 && kind < 8) begin
                seq.push_back(8'($urandom_range(1, 127)));
            end else begin
                if (enc == ENC_SJIS) begin
                    seq.push_back(8'($urandom_range(128, 255)));
                end else if (len == 2) begin
                    seq.push_back(LEAD2_CODE | 8'($urandom_range(0, 31)));
                end else if (len == 3) begin
                    seq.push_back(LEAD3_CODE | 8'($urandom_range(0, 15)));
                end else begin
                    seq.push_back(LEAD4_CODE | 8'($urandom_range(0, 7)));
                end
                trail = (kind == 2) ? $urandom_range(0, len - 2) : len - 1;
                repeat (trail) begin
                    seq.push_back((enc == ENC_SJIS) ? 8'($urandom_range(1, 255))
                                                    : BIT7_MASK | 8'($urandom_range(0, 63)));
                end
                if (kind == 2) begin
                    seq.push_back(8'h00);
                end
            end
            foreach (seq[i]) begin
                text_bytes.push_back(seq[i]);
            end
            added += seq.size();
            text_len += seq.size();
        end
    endtask

    task automatic settle();
        while (text_sent != text_len || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_encoding(input t_enc enc);
        i_cfg_encoding <= enc;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        enc_setting = enc;
        drop_partial();
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : driver
        t_result next_char;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                text_sent++;
                if (predict_char(i_data_byte, next_char)) begin
                    expected_chars.push_back(next_char);
                end
                tx_wait = $urandom_range(0, tx_max_gap);
            end
            if (!push || !full) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    push <= 1'b0;
                end else if (text_bytes.size() != 0) begin
                    push <= 1'b1;
                    i_data_byte <= text_bytes.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_chars.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("%0t: unexpected word, char_code 0x%0h", $time, o_char_code);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    check_field("char_code", want.char_code, o_char_code);
                    check_field("code_bytes", want.code_bytes, o_code_bytes);
                    check_field("malformed", want.malformed, o_malformed);
                    check_field("truncated", want.truncated, o_truncated);
                    check_field("end_of_text", want.end_of_text, o_end_of_text);
                end
                rx_wait = $urandom_range(0, rx_max_gap);
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The text out of reset is UTF-8; it ends on an open lead byte, which
        // the following encoding write must discard.
        queue_packed({8'h7f, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98,
                      8'h80, 8'h80, 8'hf8, 8'h00, 8'he2, 8'h82, 8'h00, 8'he2}, 17);
        settle();
        write_encoding(ENC_SJIS);
        queue_packed({8'hff, 8'h01, 8'h81, 8'h00}, 4);
        settle();
        write_encoding(ENC_UTF16);
        queue_packed({8'h41, 8'h00, 8'h00}, 3);
        settle();
        write_encoding(ENC_BYTE);
        queue_packed({8'h00, 8'hff}, 2);

        foreach (phase_plan[p]) begin
            settle();
            write_encoding(phase_plan[p]);
            tx_max_gap = (p % 3 == 1 || p == 3) ? 0 : MAX_GAP;
            rx_max_gap = (p % 3 == 1) ? 0 : MAX_GAP;
            add_text(phase_plan[p], PHASE_BYTES);
            if (p == 3) begin
                hold_req++;
            end
        end

        settle();
        if (err_count == 0 && expected_chars.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
